@@ hdl/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, operation codes and calendar helpers for the date decrementer.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int AMOUNT_W = 16;
    localparam int YEAR_W   = 16;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int RES_W    = 9;   // year residue modulo 400

    localparam logic [1:0] OP_DAYS   = 2'd0;
    localparam logic [1:0] OP_MONTHS = 2'd1;
    localparam logic [1:0] OP_YEARS  = 2'd2;

    localparam int RES_MOD      = 400;
    // (year + 32768) mod 400 is formed first; this offset recovers year mod 400
    localparam int RES_OFFSET   = (RES_MOD - (32768 % RES_MOD)) % RES_MOD;
    localparam int RES_YEAR_MAX = 32767 % RES_MOD;

    // quotient by 400 as (u * RES_RECIP) >> RES_SHIFT, exact for any 16-bit u
    localparam int RES_RECIP_W = 17;
    localparam int RES_RECIP   = 83887;   // ceil(2**25 / 400)
    localparam int RES_SHIFT   = 25;
    localparam int QUO_W       = 8;       // 65535 / 400 fits in 8 bits

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic signed [YEAR_W-1:0] YEAR_MIN = 16'sh8000;
    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 16'sh7FFF;

    typedef struct packed {
        logic load;        // capture an input word
        logic mod_step;    // one stage of the residue reduction
        logic res_fix;     // shift residue to year mod 400
        logic load_month;  // take one month length as the day budget
        logic step;        // one borrow step
        logic commit;      // write the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       mod_last;
        logic       rem_zero;
        logic       cnt_zero;
        logic       out_free;
    } t_dp_sts;

    function automatic logic is_leap(input logic [RES_W-1:0] res);
        is_leap = (res == RES_W'(0)) ||
                  ((res[1:0] == 2'b00) && (res != RES_W'(100)) &&
                   (res != RES_W'(200)) && (res != RES_W'(300)));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        if (m == MONTH_FEB) begin
            month_len = leap ? 5'd29 : 5'd28;
        end else if (m <= MONTH_JUL) begin
            month_len = m[0] ? 5'd31 : 5'd30;
        end else begin
            month_len = m[0] ? 5'd30 : 5'd31;
        end
    endfunction

endpackage

@@ hdl/gregorian_date_decrement.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_decrement
// Steps a Gregorian date back by a count of days, months or years.
// ----------------------------------------------------------------------------
// Input i_in_valid / o_in_stall takes one word: op, amount and the starting
// date. Output o_out_valid / i_out_stall returns the resulting date, one word
// per input word. One word is worked on at a time; o_in_stall is high from
// acceptance until the result is written to the output register.
// Setup forms year mod 400 by a reciprocal multiply, then a subtract, then an
// offset correction. Day mode then makes one borrow step per month crossed,
// plus one more when the count ends inside a month; month mode takes each
// month of the count as a day budget, then makes its borrow steps. Year mode
// and an unused op skip setup and go straight to the result. The next word is
// taken the cycle after its result is written.
// The result waits in its own register, so the next word is taken while it is
// held; a stalled receiver only holds the block once the next result is ready.
// Reset (synchronous, active low) returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
module gregorian_date_decrement #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_op,
    input  logic [gdd_pkg::AMOUNT_W-1:0]          i_amount,
    input  logic [gdd_pkg::DAY_W-1:0]             i_day_in,
    input  logic [gdd_pkg::MONTH_W-1:0]           i_month_in,
    input  logic signed [gdd_pkg::YEAR_W-1:0]     i_year_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [gdd_pkg::DAY_W-1:0]             o_day_out,
    output logic [gdd_pkg::MONTH_W-1:0]           o_month_out,
    output logic signed [gdd_pkg::YEAR_W-1:0]     o_year_out
);
    import gdd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: decides what the datapath does each cycle
    gdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: date, residue, budget and the result register
    gdd_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_op),
        .i_amount    (i_amount),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out)
    );

    // a taken word closes the input until its result is written
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input left open after accepting a word");

    // never overwrite a result the receiver has not taken
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // a result appears only after a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

endmodule

@@ hdl/gdd_dp.sv @@
// ----------------------------------------------------------------------------
// gdd_dp
// Date datapath: date registers, year residue, day budget and result register.
// ----------------------------------------------------------------------------
module gdd_dp #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gdd_pkg::t_dp_cmd                      i_cmd,
    output gdd_pkg::t_dp_sts                      o_sts,
    input  logic [1:0]                            i_op,
    input  logic [gdd_pkg::AMOUNT_W-1:0]          i_amount,
    input  logic [gdd_pkg::DAY_W-1:0]             i_day_in,
    input  logic [gdd_pkg::MONTH_W-1:0]           i_month_in,
    input  logic signed [gdd_pkg::YEAR_W-1:0]     i_year_in,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [gdd_pkg::DAY_W-1:0]             o_day_out,
    output logic [gdd_pkg::MONTH_W-1:0]           o_month_out,
    output logic signed [gdd_pkg::YEAR_W-1:0]     o_year_out
);
    import gdd_pkg::*;

    localparam int CW = (COUNT_BITS < AMOUNT_W) ? COUNT_BITS : AMOUNT_W;
    localparam int NW = (CW > DAY_W) ? CW : DAY_W;
    localparam int PW = YEAR_W + RES_RECIP_W;

    logic [1:0]               r_op;
    logic [CW-1:0]            r_cnt,   n_cnt;
    logic [NW-1:0]            r_rem,   n_rem;
    logic [DAY_W-1:0]         r_day,   n_day;
    logic [MONTH_W-1:0]       r_month, n_month;
    logic signed [YEAR_W-1:0] r_year,  n_year;
    logic [RES_W-1:0]         r_res,   n_res;
    logic [YEAR_W-1:0]        r_year_u;
    logic [QUO_W-1:0]         r_quo;
    logic                     r_mod_ph;
    logic                     r_out_valid;
    logic [DAY_W-1:0]         r_day_out;
    logic [MONTH_W-1:0]       r_month_out;
    logic signed [YEAR_W-1:0] r_year_out;

    logic                     work_mode;
    logic [DAY_W-1:0]         day_norm;
    logic [MONTH_W-1:0]       month_norm;
    logic [PW-1:0]            quo_prod;
    logic [YEAR_W-1:0]        quo_x400;
    logic [RES_W:0]           fix_sum;

    assign work_mode  = (i_op == OP_DAYS) || (i_op == OP_MONTHS);
    assign day_norm   = (i_day_in == '0) ? DAY_W'(1) : i_day_in;
    assign month_norm = (i_month_in == '0)      ? MONTH_JAN :
                        (i_month_in > MONTH_DEC) ? MONTH_DEC : i_month_in;
    assign quo_prod   = PW'(r_year_u) * PW'(RES_RECIP);
    assign quo_x400   = YEAR_W'(r_quo) * YEAR_W'(RES_MOD);
    assign fix_sum    = (RES_W+1)'(r_res) + (RES_W+1)'(RES_OFFSET);

    always_comb begin
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_res   = r_res;
        if (i_cmd.load) begin
            n_cnt   = i_amount[CW-1:0];
            n_rem   = NW'(i_amount[CW-1:0]);
            n_day   = work_mode ? day_norm : i_day_in;
            n_month = work_mode ? month_norm : i_month_in;
            n_year  = i_year_in;
            n_res   = '0;
        end else if (i_cmd.mod_step) begin
            // second stage: remainder from the registered quotient
            if (r_mod_ph) begin
                n_res = RES_W'(r_year_u - quo_x400);
            end
        end else if (i_cmd.res_fix) begin
            n_res = (fix_sum >= (RES_W+1)'(RES_MOD)) ?
                    RES_W'(fix_sum - (RES_W+1)'(RES_MOD)) : RES_W'(fix_sum);
        end else if (i_cmd.load_month) begin
            n_rem = NW'(month_len(r_month, is_leap(r_res)));
            n_cnt = r_cnt - CW'(1);
        end else if (i_cmd.step) begin
            if (NW'(r_day) > r_rem) begin
                // budget ends inside this month
                n_day = r_day - r_rem[DAY_W-1:0];
                n_rem = '0;
            end else begin
                // spend the whole month and borrow from the one before
                n_rem = r_rem - NW'(r_day);
                if (r_month <= MONTH_JAN) begin
                    n_month = MONTH_DEC;
                    if (r_year == YEAR_MIN) begin
                        n_year = YEAR_MAX;
                        n_res  = RES_W'(RES_YEAR_MAX);
                    end else begin
                        n_year = r_year - YEAR_W'(1);
                        n_res  = (r_res == '0) ? RES_W'(RES_MOD - 1) : r_res - RES_W'(1);
                    end
                end else begin
                    n_month = r_month - MONTH_W'(1);
                end
                n_day = month_len(n_month, is_leap(n_res));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_res   <= n_res;
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_year_u <= i_year_in ^ YEAR_MIN;
            r_mod_ph <= 1'b0;
        end else if (i_cmd.mod_step) begin
            r_quo    <= quo_prod[RES_SHIFT +: QUO_W];
            r_mod_ph <= 1'b1;
        end
        if (i_cmd.commit) begin
            r_day_out   <= r_day;
            r_month_out <= r_month;
            r_year_out  <= (r_op == OP_YEARS) ? r_year - YEAR_W'(r_cnt) : r_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.mod_last = r_mod_ph;
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_day_out   = r_day_out;
    assign o_month_out = r_month_out;
    assign o_year_out  = r_year_out;

endmodule

@@ hdl/gdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdd_ctrl
// Sequencer for the date decrementer: setup, borrow loop and result hand-off.
// ----------------------------------------------------------------------------
module gdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_op,
    input  gdd_pkg::t_dp_sts i_sts,
    output gdd_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);
    import gdd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_NEXTM = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ((i_op == OP_DAYS) || (i_op == OP_MONTHS)) ? S_MOD : S_DONE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.res_fix = 1'b1;
                n_state = (i_sts.op == OP_DAYS) ? S_STEP : S_NEXTM;
            end
            S_NEXTM: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.load_month = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.rem_zero) begin
                    n_state = (i_sts.op == OP_DAYS) ? S_DONE : S_NEXTM;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gregorian_date_decrement. A short table of
// hand-picked dates (calendar edges, year wrap, odd field values, every
// operation) is followed by random words. Each result is compared with a
// typed value or an in-bench calendar walk; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import gdd_pkg::*;

    // op 3 has no code in the package; the block passes the date through
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Input word as presented on the input channel
    typedef struct packed {
        logic [1:0]               op;
        logic [AMOUNT_W-1:0]      amount;
        logic [DAY_W-1:0]         day;
        logic [MONTH_W-1:0]       month;
        logic signed [YEAR_W-1:0] year;
    } date_word_t;

    // Result word as returned on the output channel
    typedef struct packed {
        logic [DAY_W-1:0]         day;
        logic [MONTH_W-1:0]       month;
        logic signed [YEAR_W-1:0] year;
    } date_t;

    // One row of the directed table; 'typed' marks a hand-written result
    typedef struct packed {
        date_word_t word;
        bit         typed;
        date_t      want;
    } date_case_t;

    // Working date for the calendar walk, wide enough to never overflow
    typedef struct packed {
        int unsigned d;
        int unsigned m;
        int          y;
    } cal_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_op;
    logic [AMOUNT_W-1:0]      i_amount;
    logic [DAY_W-1:0]         i_day_in;
    logic [MONTH_W-1:0]       i_month_in;
    logic signed [YEAR_W-1:0] i_year_in;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [DAY_W-1:0]         o_day_out;
    logic [MONTH_W-1:0]       o_month_out;
    logic signed [YEAR_W-1:0] o_year_out;

    date_case_t date_cases [$];   // directed table
    date_t      dates_due  [$];   // results still owed by the block, oldest first
    date_t      oldest;

    int n_fail      = 0;
    int n_checked   = 0;
    int n_directed  = 0;
    int in_quiet    = 0;          // words left in a no-gap stretch, input side
    int out_quiet   = 0;          // same for the output stall
    int words_by_op [4] = '{0, 0, 0, 0};

    gregorian_date_decrement dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_amount    (i_amount),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Calendar walk
    // ------------------------------------------------------------------------

    // Gregorian month length; the year is a plain signed integer here
    function automatic int unsigned days_in_month(input int unsigned m, input int y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        if (m == 2) begin
            return leap ? 29 : 28;
        end
        if (m <= 7) begin
            return (m % 2 == 1) ? 31 : 30;
        end
        return (m % 2 == 1) ? 30 : 31;
    endfunction

    // Step back n days: eat the day of month in one go where it suffices,
    // otherwise borrow a whole month (and a year at January, wrapping the
    // 16-bit year from its lowest value to its highest).
    function automatic cal_t walk_back(input cal_t c, input longint unsigned n);
        while (n > 0) begin
            if (longint'(c.d) > n) begin
                c.d = c.d - int'(n);
                n   = 0;
            end else begin
                n = n - c.d;
                if (c.m <= 1) begin
                    c.m = 12;
                    c.y = (c.y == -32768) ? 32767 : c.y - 1;
                end else begin
                    c.m = c.m - 1;
                end
                c.d = days_in_month(c.m, c.y);
            end
        end
        return c;
    endfunction

    // Work out the date the block must return for one input word
    function automatic date_t earlier_date(input date_word_t s);
        cal_t            c;
        date_t           r;
        longint unsigned k;
        r.day   = s.day;
        r.month = s.month;
        r.year  = s.year;
        case (s.op) inside
            OP_YEARS: begin
                // year only, 16-bit wrap; day and month pass untouched
                r.year = s.year - s.amount;
            end
            OP_DAYS, OP_MONTHS: begin
                c.d = s.day;
                c.m = s.month;
                c.y = int'($signed(s.year));
                // clamp out-of-range day and month before stepping
                if (c.d == 0) c.d = 1;
                if (c.m == 0) c.m = 1;
                if (c.m > 12) c.m = 12;
                if (s.op == OP_DAYS) begin
                    c = walk_back(c, s.amount);
                end else begin
                    // each month step takes the length of the month held now
                    for (k = 0; k < s.amount; k++) begin
                        c = walk_back(c, days_in_month(c.m, c.y));
                    end
                end
                r.day   = DAY_W'(c.d);
                r.month = MONTH_W'(c.m);
                r.year  = YEAR_W'(c.y);
            end
            default: ;  // unused op: date comes back as it went in
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_case(input logic [1:0] op, input int amount, input int d,
                            input int m, input int y, input bit typed,
                            input int wd, input int wm, input int wy);
        date_case_t c;
        c.word.op     = op;
        c.word.amount = AMOUNT_W'(amount);
        c.word.day    = DAY_W'(d);
        c.word.month  = MONTH_W'(m);
        c.word.year   = YEAR_W'(y);
        c.typed       = typed;
        c.want.day    = DAY_W'(wd);
        c.want.month  = MONTH_W'(wm);
        c.want.year   = YEAR_W'(wy);
        date_cases.push_back(c);
    endtask

    // Draw a random idle gap for one word, with occasional stretches of none
    task automatic draw_wait(inout int quiet, output int cycles);
        if (quiet > 0) begin
            quiet--;
            cycles = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            quiet  = $urandom_range(5, 20);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 15);
        end
    endtask

    // Mostly well-formed dates; some with day and month anywhere in their
    // field. Years lean to the wrap points and to century boundaries.
    function automatic date_word_t random_word();
        date_word_t  s;
        int          y;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            s.op = OP_DAYS;
        end else if (pick < 14) begin
            s.op = OP_MONTHS;
        end else if (pick < 19) begin
            s.op = OP_YEARS;
        end else begin
            s.op = OP_UNUSED;
        end
        case ($urandom_range(0, 4))
            0:       y = -32768 + int'($urandom_range(0, 2));
            1:       y = 32767 - int'($urandom_range(0, 2));
            2:       y = (int'($urandom_range(0, 320)) - 160) * 100;
            default: y = int'($urandom_range(0, 65535)) - 32768;
        endcase
        s.year  = YEAR_W'(y);
        s.month = MONTH_W'($urandom_range(1, 12));
        s.day   = DAY_W'($urandom_range(1, days_in_month(s.month, y)));
        if ($urandom_range(0, 4) == 0) begin
            s.day   = DAY_W'($urandom_range(0, 31));
            s.month = MONTH_W'($urandom_range(0, 15));
        end
        case (s.op)
            OP_DAYS: begin
                // day walks step once per month crossed: full range is cheap
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: s.amount = AMOUNT_W'($urandom_range(0, 60));
                    5, 6, 7:       s.amount = AMOUNT_W'($urandom_range(0, 1000));
                    default:       s.amount = AMOUNT_W'($urandom_range(0, 65535));
                endcase
            end
            OP_MONTHS: begin
                // month walks load a budget and borrow per month: keep them short
                if ($urandom_range(0, 6) == 0) begin
                    s.amount = AMOUNT_W'($urandom_range(0, 1023));
                end else begin
                    s.amount = AMOUNT_W'($urandom_range(0, 30));
                end
            end
            default: s.amount = AMOUNT_W'($urandom_range(0, 65535));
        endcase
        return s;
    endfunction

    // Present one word, hold it until taken, then log the result it owes.
    // Valid stays high into the next word when that word has no gap.
    task automatic send_word(input date_word_t s, input date_t want);
        int gap;
        draw_wait(in_quiet, gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= s.op;
        i_amount   <= s.amount;
        i_day_in   <= s.day;
        i_month_in <= s.month;
        i_year_in  <= s.year;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        dates_due.push_back(want);
        words_by_op[s.op]++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        n_fail++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall at random, compare every word taken
    // ------------------------------------------------------------------------

    // Hold the output stalled through reset, then draw a stall per result
    initial begin : out_stall_drive
        int hold;
        i_out_stall <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            draw_wait(out_quiet, hold);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            // stall is low from here on, so a valid word is a taken word
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Compare each word taken with the oldest result owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dates_due.size() == 0) begin
                report_mismatch("result word with nothing owed, day", o_day_out, 0);
            end else begin
                oldest = dates_due.pop_front();
                n_checked++;
                if (o_day_out !== oldest.day) begin
                    report_mismatch("day", o_day_out, oldest.day);
                end
                if (o_month_out !== oldest.month) begin
                    report_mismatch("month", o_month_out, oldest.month);
                end
                if (o_year_out !== oldest.year) begin
                    report_mismatch("year", int'(o_year_out), int'($signed(oldest.year)));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        date_word_t w;
        int         n_random;
        // drive every input to a known value under reset, then release it
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_DAYS;
        i_amount   <= '0;
        i_day_in   <= 5'd1;
        i_month_in <= MONTH_JAN;
        i_year_in  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: op, amount, day, month, year, typed, expected d/m/y
        // zero days leaves the date alone
        add_case(OP_DAYS,       0, 15,  6,   2024, 1'b1, 15,  6,   2024);
        // borrow into the previous year
        add_case(OP_DAYS,       1,  1,  1,   2000, 1'b1, 31, 12,   1999);
        // leap February: divisible by 400, not a leap century, plain leap year
        add_case(OP_DAYS,       1,  1,  3,   2000, 1'b1, 29,  2,   2000);
        add_case(OP_DAYS,       1,  1,  3,   1900, 1'b1, 28,  2,   1900);
        add_case(OP_DAYS,       1,  1,  3,   2024, 1'b1, 29,  2,   2024);
        // year underflow wraps to the top of the range; year 0 borrows to -1
        add_case(OP_DAYS,       1,  1,  1, -32768, 1'b1, 31, 12,  32767);
        add_case(OP_DAYS,       1,  1,  1,      0, 1'b1, 31, 12,     -1);
        // largest count from both ends of the year range
        add_case(OP_DAYS,   65535, 31, 12,  32767, 1'b0,  0,  0,      0);
        add_case(OP_DAYS,   65535,  1,  1, -32768, 1'b0,  0,  0,      0);
        // day zero with month zero, then a month above December
        add_case(OP_DAYS,       5,  0,  0,    100, 1'b0,  0,  0,      0);
        add_case(OP_DAYS,       3, 31, 15,      7, 1'b0,  0,  0,      0);
        // day beyond the month length just counts down
        add_case(OP_DAYS,       2, 31,  2,   2023, 1'b1, 29,  2,   2023);
        add_case(OP_DAYS,     366,  1,  3,   2001, 1'b0,  0,  0,      0);
        // month mode
        add_case(OP_MONTHS,     0, 31, 12,      0, 1'b1, 31, 12,      0);
        add_case(OP_MONTHS,     1, 31,  3,   2023, 1'b0,  0,  0,      0);
        add_case(OP_MONTHS,    12, 29,  2,   2024, 1'b0,  0,  0,      0);
        add_case(OP_MONTHS,     1,  0,  0, -32768, 1'b0,  0,  0,      0);
        add_case(OP_MONTHS,     3, 20, 14,      1, 1'b0,  0,  0,      0);
        add_case(OP_MONTHS, 65535, 31, 12,  32767, 1'b0,  0,  0,      0);
        // year mode: wrap both ways, odd day and month pass straight through
        add_case(OP_YEARS,      0, 31, 12,  32767, 1'b1, 31, 12,  32767);
        add_case(OP_YEARS,      1,  1,  1, -32768, 1'b1,  1,  1,  32767);
        add_case(OP_YEARS,  65535, 29,  2,      0, 1'b1, 29,  2,      1);
        add_case(OP_YEARS,    100,  0, 15,      5, 1'b1,  0, 15,    -95);
        // unused op returns the word's date as is
        add_case(OP_UNUSED, 65535,  0,  0,     -1, 1'b1,  0,  0,     -1);
        add_case(OP_UNUSED,     7, 31, 13,  12345, 1'b1, 31, 13,  12345);

        foreach (date_cases[i]) begin
            send_word(date_cases[i].word,
                      date_cases[i].typed ? date_cases[i].want
                                          : earlier_date(date_cases[i].word));
        end
        n_directed = date_cases.size();

        // Random words, each checked against the calendar walk
        repeat (75) begin
            w = random_word();
            send_word(w, earlier_date(w));
        end
        i_in_valid <= 1'b0;

        // Drain, then idle a while to catch any stray result
        while (dates_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        n_random = words_by_op.sum() - n_directed;
        $display("%0d directed, %0d random words; days %0d, months %0d, years %0d, unused %0d",
                 n_directed, n_random, words_by_op[0], words_by_op[1],
                 words_by_op[2], words_by_op[3]);
        $display("%0d result words compared, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under half of this
    initial begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
